>>> rtl/lcpbr_pkg.sv
// Shared types and constants for the LCP interval best repeat block.
`timescale 1ns / 1ps
`default_nettype none

package lcpbr_pkg;

    localparam int CNT_W     = 13;
    localparam int LEN_W     = 12;
    localparam int SCORE_W   = 24;
    localparam int PROD_W    = CNT_W + LEN_W;

    localparam int MAX_SUFFIXES_DEF = 4096;

    localparam logic [CNT_W-1:0]   CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [SCORE_W-1:0] t_score;
    typedef logic [PROD_W-1:0]  t_prod;

    // One interval on the stack.
    typedef struct packed {
        t_count cnt;
        t_len   start;
        t_len   len;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

>>> rtl/lcpbr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module lcpbr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/lcp_interval_best_repeat_unit.sv
// Top level of the LCP interval best repeat block: stack scan, best tracking, result register.
`timescale 1ns / 1ps
`default_nettype none

// This block scans suffix array entries, presented from the last sorted suffix
// to the first, and finds the repeated substring whose occurrence count times
// length is greatest. Every entry carries its suffix start and its LCP with the
// preceding sorted suffix. A stack of LCP intervals (count, start, length) is
// kept in one synchronous RAM of MAX_SUFFIXES entries; the stack height and the
// current best live in registers. An input transaction is taken only when the
// scanner is idle. The accepting cycle issues the read of the stack top, and
// each following cycle either pops that top (adding its count, scoring it and
// issuing the read of the next entry) or pushes the new interval and returns to
// idle. An entry is thus accepted, pops its intervals one by one and ends with
// a push; each entry is pushed once and popped at most once. The registered
// read of the stack RAM paces each pop. On an entry marked last, the best
// score (saturated to 24 bits), length and start are placed in the output
// register, the height is cleared and the best re-seeded as below, so the
// next sequence can follow at once. The result register frees the input side
// while a result waits to be taken; only a second last entry waits for the
// first result to leave. Counts saturate at 8191. The stack RAM needs no
// clearing pass because it is only read below the stack height. Writing
// seq_length re-seeds the best interval to count 1, start 0 and that length;
// it should be written only between sequences.
module lcp_interval_best_repeat_unit #(
    parameter int MAX_SUFFIXES = lcpbr_pkg::MAX_SUFFIXES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [lcpbr_pkg::LEN_W-1:0] i_seq_length,

    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [lcpbr_pkg::LEN_W-1:0] i_suffix_start,
    input  wire logic [lcpbr_pkg::LEN_W-1:0] i_lcp_prev,
    input  wire logic                      i_is_last,

    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [lcpbr_pkg::SCORE_W-1:0]  o_best_score,
    output logic [lcpbr_pkg::LEN_W-1:0]    o_best_length,
    output logic [lcpbr_pkg::LEN_W-1:0]    o_best_start
);

    import lcpbr_pkg::*;

    localparam int AW = $clog2(MAX_SUFFIXES);
    localparam int HW = $clog2(MAX_SUFFIXES + 1);
    localparam logic [HW-1:0] HEIGHT_MAX = HW'(MAX_SUFFIXES);

    // Scanner states.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic            r_state,     n_state;
    logic [HW-1:0]   r_height,    n_height;
    t_len            r_seq_len,   n_seq_len;

    // The entry being processed.
    t_len            r_start,     n_start;
    t_len            r_lcp,       n_lcp;
    logic            r_last,      n_last;
    t_count          r_cnt,       n_cnt;

    // Best interval so far and its full product.
    t_count          r_best_cnt,  n_best_cnt;
    t_len            r_best_len,  n_best_len;
    t_len            r_best_start, n_best_start;
    t_prod           r_best_prod, n_best_prod;

    // Result register.
    logic            r_out_valid, n_out_valid;
    t_score          r_out_score, n_out_score;
    t_len            r_out_len,   n_out_len;
    t_len            r_out_start, n_out_start;

    // Stack RAM ports.
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    t_entry          w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [ENTRY_W-1:0] w_rdata_raw;
    t_entry          w_top;

    logic            w_accept;
    logic            w_pop;
    logic            w_out_block;
    logic [CNT_W:0]  w_sum;
    t_count          w_cnt_sat;
    t_prod           w_prod;
    logic [HW-1:0]   w_rd_height;

    lcpbr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SUFFIXES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_top       = t_entry'(w_rdata_raw);
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;

    // The top read out of the RAM is the entry at height - 1, because the read
    // address always follows the next height value.
    assign w_pop       = (r_state == S_SCAN) && (r_height != '0) && (r_lcp <= w_top.len);
    assign w_out_block = r_last && r_out_valid && i_out_stall;

    assign w_sum     = {1'b0, r_cnt} + {1'b0, w_top.cnt};
    assign w_cnt_sat = (w_sum > {1'b0, CNT_MAX}) ? CNT_MAX : w_sum[CNT_W-1:0];
    assign w_prod    = {{LEN_W{1'b0}}, w_cnt_sat} * {{CNT_W{1'b0}}, w_top.len};

    assign w_rd_height = n_height - HW'(1);
    assign w_raddr     = w_rd_height[AW-1:0];

    assign w_waddr = r_height[AW-1:0];
    assign w_wdata = '{cnt: r_cnt, start: r_start, len: r_lcp};

    always_comb begin
        n_state      = r_state;
        n_height     = r_height;
        n_seq_len    = r_seq_len;
        n_start      = r_start;
        n_lcp        = r_lcp;
        n_last       = r_last;
        n_cnt        = r_cnt;
        n_best_cnt   = r_best_cnt;
        n_best_len   = r_best_len;
        n_best_start = r_best_start;
        n_best_prod  = r_best_prod;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_score  = r_out_score;
        n_out_len    = r_out_len;
        n_out_start  = r_out_start;
        w_we         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_start = i_suffix_start;
                    n_lcp   = i_lcp_prev;
                    n_last  = i_is_last;
                    n_cnt   = CNT_ONE;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_pop) begin
                    n_cnt    = w_cnt_sat;
                    n_height = r_height - HW'(1);
                    if (w_prod > r_best_prod) begin
                        n_best_cnt   = w_cnt_sat;
                        n_best_len   = w_top.len;
                        n_best_start = w_top.start;
                        n_best_prod  = w_prod;
                    end
                end else if (!w_out_block) begin
                    if (r_height < HEIGHT_MAX) begin
                        w_we     = 1'b1;
                        n_height = r_height + HW'(1);
                    end
                    n_state = S_IDLE;
                    if (r_last) begin
                        n_out_valid  = 1'b1;
                        n_out_score  = (r_best_prod > {1'b0, SCORE_MAX}) ?
                                       SCORE_MAX : r_best_prod[SCORE_W-1:0];
                        n_out_len    = r_best_len;
                        n_out_start  = r_best_start;
                        n_height     = '0;
                        n_best_cnt   = CNT_ONE;
                        n_best_len   = r_seq_len;
                        n_best_start = '0;
                        n_best_prod  = {{CNT_W{1'b0}}, r_seq_len};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A configuration write re-seeds the best interval.
        if (i_cfg_valid && o_cfg_ready) begin
            n_seq_len    = i_seq_length;
            n_best_cnt   = CNT_ONE;
            n_best_len   = i_seq_length;
            n_best_start = '0;
            n_best_prod  = {{CNT_W{1'b0}}, i_seq_length};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_height     <= '0;
            r_seq_len    <= '0;
            r_best_cnt   <= CNT_ONE;
            r_best_len   <= '0;
            r_best_start <= '0;
            r_best_prod  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_height     <= n_height;
            r_seq_len    <= n_seq_len;
            r_best_cnt   <= n_best_cnt;
            r_best_len   <= n_best_len;
            r_best_start <= n_best_start;
            r_best_prod  <= n_best_prod;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_lcp       <= n_lcp;
        r_last      <= n_last;
        r_cnt       <= n_cnt;
        r_out_score <= n_out_score;
        r_out_len   <= n_out_len;
        r_out_start <= n_out_start;
    end

    assign o_out_valid   = r_out_valid;
    assign o_best_score  = r_out_score;
    assign o_best_length = r_out_len;
    assign o_best_start  = r_out_start;

    // The stack never grows past its capacity.
    a_height_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_height <= HEIGHT_MAX)
        else $error("stack height exceeds capacity");

    // An accepted entry always moves the scanner to the scan state.
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN))
        else $error("accepted entry did not start a scan");

    // A new result appears only after finishing an entry marked last.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |->
            ($past(r_state == S_SCAN) && $past(r_last) && !$past(w_pop)))
        else $error("result raised without a finished last entry");

    // The stored best product matches the stored count and length.
    a_best_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_prod == ({{LEN_W{1'b0}}, r_best_cnt} * {{CNT_W{1'b0}}, r_best_len}))
        else $error("best product out of step with best count and length");

    // The best count is never zero.
    a_best_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_cnt != '0)
        else $error("best count is zero");

endmodule

`default_nettype wire
